/* src/psru_pkg.sv */
// Shared constants and types for the pad sample ring update block.
`timescale 1ns / 1ps
package psru_pkg;

   localparam int PAD_SLOTS_DEFAULT   = 8;
   localparam int TOUCH_SLOTS_DEFAULT = 8;
   localparam int AVG_DEPTH_DEFAULT   = 3;

   localparam int PAD_W   = 32;
   localparam int STICK_W = 16;
   localparam int TOUCH_W = 16;
   localparam int SLOT_W  = 3;

   localparam logic [PAD_W-1:0] LOCAL_MASK  = 32'h0000_3FFF;
   localparam logic [PAD_W-1:0] REMOTE_MASK = 32'hF000_3FFF;

   localparam int REMOTE_TOUCH_BIT = 20;
   localparam int BIT_RIGHT        = 28;
   localparam int BIT_LEFT         = 29;
   localparam int BIT_UP           = 30;
   localparam int BIT_DOWN         = 31;

   localparam logic [32:0] RADIUS_SQ_LIMIT = 33'd1600;
   // tan 30 and tan 60 degrees, 16 fraction bits
   localparam logic [16:0] TAN30_Q16 = 17'd37837;
   localparam logic [16:0] TAN60_Q16 = 17'd113512;

   typedef struct packed {
      logic                       remote;
      logic [PAD_W-1:0]           bits;
      logic signed [STICK_W-1:0]  avg_x;
      logic signed [STICK_W-1:0]  avg_y;
      logic [SLOT_W-1:0]          pad_slot;
      logic                       pad_wrapped;
      logic [SLOT_W-1:0]          touch_slot;
      logic                       touch_wrapped;
      logic [TOUCH_W-1:0]         touch_col;
      logic [TOUCH_W-1:0]         touch_row;
      logic                       touch_valid;
   } stage_type;

   typedef struct packed {
      logic [SLOT_W-1:0]          pad_slot;
      logic [PAD_W-1:0]           pad_state;
      logic [PAD_W-1:0]           pressed_now;
      logic [PAD_W-1:0]           released_now;
      logic signed [STICK_W-1:0]  avg_x;
      logic signed [STICK_W-1:0]  avg_y;
      logic                       pad_wrapped;
      logic [SLOT_W-1:0]          touch_slot;
      logic [TOUCH_W-1:0]         touch_col;
      logic [TOUCH_W-1:0]         touch_row;
      logic                       touch_valid;
      logic                       touch_wrapped;
   } result_type;

endpackage

/* src/psru_if.sv */
// Channel interfaces: poll tick input, ring update result, mode register write.
`timescale 1ns / 1ps
interface psru_req_if import psru_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [PAD_W-1:0]           pad_bits;
   logic signed [STICK_W-1:0]  stick_x;
   logic signed [STICK_W-1:0]  stick_y;
   logic [TOUCH_W-1:0]         touch_x;
   logic [TOUCH_W-1:0]         touch_y;
   logic                       touch_pressed;

   modport source (output valid, pad_bits, stick_x, stick_y, touch_x, touch_y,
                   touch_pressed, input ready);
   modport sink (input valid, pad_bits, stick_x, stick_y, touch_x, touch_y,
                 touch_pressed, output ready);
endinterface

interface psru_rsp_if import psru_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [SLOT_W-1:0]          pad_slot;
   logic [PAD_W-1:0]           pad_state;
   logic [PAD_W-1:0]           pressed_now;
   logic [PAD_W-1:0]           released_now;
   logic signed [STICK_W-1:0]  avg_x;
   logic signed [STICK_W-1:0]  avg_y;
   logic                       pad_wrapped;
   logic [SLOT_W-1:0]          touch_slot;
   logic [TOUCH_W-1:0]         touch_col;
   logic [TOUCH_W-1:0]         touch_row;
   logic                       touch_valid;
   logic                       touch_wrapped;

   modport source (output valid, pad_slot, pad_state, pressed_now, released_now, avg_x,
                   avg_y, pad_wrapped, touch_slot, touch_col, touch_row, touch_valid,
                   touch_wrapped, input ready);
   modport sink (input valid, pad_slot, pad_state, pressed_now, released_now, avg_x,
                 avg_y, pad_wrapped, touch_slot, touch_col, touch_row, touch_valid,
                 touch_wrapped, output ready);
endinterface

interface psru_csr_if ();
   logic valid;
   logic ready;
   logic remote_mode;

   modport source (output valid, remote_mode, input ready);
   modport sink (input valid, remote_mode, output ready);
endinterface

/* src/pad_sample_ring_update_core.sv */
// Pad sample ring update: top level with stick averaging and direction decode.
`timescale 1ns / 1ps
// One poll tick per transfer on req_chan gives one result transfer on rsp_chan. A tick is
// accepted every cycle when the result side keeps up. The stick average and its reciprocal
// multiply sit before the middle register, the direction decode and change masks before the
// output register, and each result passes through both. The output register and the middle
// stage let a new tick enter while a result waits. remote_mode is written through csr_chan,
// which is always ready, and must only change while no tick is in flight. Pad and touch
// slots count modulo PAD_SLOTS and TOUCH_SLOTS and are reported in their low three bits;
// the stick average spans AVG_DEPTH samples.
module pad_sample_ring_update_core
   import psru_pkg::*;
#(
   parameter int PAD_SLOTS   = PAD_SLOTS_DEFAULT,
   parameter int TOUCH_SLOTS = TOUCH_SLOTS_DEFAULT,
   parameter int AVG_DEPTH   = AVG_DEPTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   psru_req_if.sink    req_chan,
   psru_rsp_if.source  rsp_chan,
   psru_csr_if.sink    csr_chan
);

   localparam int HIST_LEN  = AVG_DEPTH - 1;
   localparam int DEPTH_LOG = $clog2(AVG_DEPTH);
   localparam int SUM_W     = STICK_W + DEPTH_LOG;
   localparam int SHIFT     = SUM_W + DEPTH_LOG;
   localparam int RECIP_W   = SHIFT + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((2 ** SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);
   localparam int PSLOT_W   = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1;
   localparam int TSLOT_W   = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

   // truncating divide by AVG_DEPTH via reciprocal multiply on the magnitude
   function automatic logic signed [STICK_W-1:0] avg_div(input logic signed [SUM_W-1:0] sum);
      logic [SUM_W-1:0]   mag;
      logic [PROD_W-1:0]  prod;
      logic [STICK_W-1:0] quo;
      mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      prod = PROD_W'(mag) * PROD_W'(RECIP);
      quo  = prod[SHIFT +: STICK_W];
      return sum[SUM_W-1] ? STICK_W'(-quo) : quo;
   endfunction

   logic                      remote_ff;
   logic [PSLOT_W-1:0]        pad_next_ff;
   logic [TSLOT_W-1:0]        touch_next_ff;
   logic [PAD_W-1:0]          prev_pad_ff;
   logic                      mid_valid_ff;
   stage_type                 mid_ff;
   stage_type                 mid_in;
   logic                      rsp_valid_ff;
   result_type                rsp_ff;
   result_type                rsp_in;
   logic signed [SUM_W-1:0]   hist_sum_x;
   logic signed [SUM_W-1:0]   hist_sum_y;
   logic                      req_fire;
   logic                      out_load;
   logic [STICK_W-1:0]        mag_x;
   logic [STICK_W-1:0]        mag_y;
   logic [32:0]               radius_sq;
   logic [32:0]               t30_prod;
   logic [32:0]               t60_prod;
   logic [32:0]               ay_q;
   logic [PAD_W-1:0]          dir_bits;
   logic [PAD_W-1:0]          state;

   assign out_load         = mid_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !mid_valid_ff || out_load;
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         remote_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         remote_ff <= csr_chan.remote_mode;
      end
   end

   generate
      if (AVG_DEPTH > 1) begin : g_hist
         logic signed [STICK_W-1:0] hist_x_ff [HIST_LEN];
         logic signed [STICK_W-1:0] hist_y_ff [HIST_LEN];

         always_comb begin
            hist_sum_x = '0;
            hist_sum_y = '0;
            for (int i = 0; i < HIST_LEN; i++) begin
               hist_sum_x = hist_sum_x + SUM_W'(hist_x_ff[i]);
               hist_sum_y = hist_sum_y + SUM_W'(hist_y_ff[i]);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               for (int i = 0; i < HIST_LEN; i++) begin
                  hist_x_ff[i] <= '0;
                  hist_y_ff[i] <= '0;
               end
            end else if (req_fire && !remote_ff) begin
               for (int i = 0; i < HIST_LEN - 1; i++) begin
                  hist_x_ff[i] <= hist_x_ff[i + 1];
                  hist_y_ff[i] <= hist_y_ff[i + 1];
               end
               hist_x_ff[HIST_LEN - 1] <= req_chan.stick_x;
               hist_y_ff[HIST_LEN - 1] <= req_chan.stick_y;
            end
         end
      end else begin : g_no_hist
         assign hist_sum_x = '0;
         assign hist_sum_y = '0;
      end
   endgenerate

   // first stage: mask, average, slot assignment
   always_comb begin
      mid_in.remote        = remote_ff;
      mid_in.bits          = req_chan.pad_bits & (remote_ff ? REMOTE_MASK : LOCAL_MASK);
      mid_in.avg_x         = remote_ff ? req_chan.stick_x
                                       : avg_div(SUM_W'(req_chan.stick_x) + hist_sum_x);
      mid_in.avg_y         = remote_ff ? req_chan.stick_y
                                       : avg_div(SUM_W'(req_chan.stick_y) + hist_sum_y);
      mid_in.pad_slot      = SLOT_W'(pad_next_ff);
      mid_in.pad_wrapped   = (pad_next_ff == '0);
      mid_in.touch_slot    = SLOT_W'(touch_next_ff);
      mid_in.touch_wrapped = (touch_next_ff == '0);
      mid_in.touch_col     = req_chan.touch_x;
      mid_in.touch_row     = req_chan.touch_y;
      mid_in.touch_valid   = remote_ff ? req_chan.pad_bits[REMOTE_TOUCH_BIT]
                                       : req_chan.touch_pressed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_next_ff   <= '0;
         touch_next_ff <= '0;
         mid_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            pad_next_ff   <= (pad_next_ff == PSLOT_W'(PAD_SLOTS - 1)) ? '0
                                                                     : pad_next_ff + PSLOT_W'(1);
            touch_next_ff <= (touch_next_ff == TSLOT_W'(TOUCH_SLOTS - 1)) ? '0
                                                               : touch_next_ff + TSLOT_W'(1);
            mid_valid_ff  <= 1'b1;
         end else if (out_load) begin
            mid_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mid_ff <= mid_in;
      end
   end

   // second stage: direction decode and change masks
   always_comb begin
      mag_x     = mid_ff.avg_x[STICK_W-1] ? STICK_W'(-mid_ff.avg_x) : STICK_W'(mid_ff.avg_x);
      mag_y     = mid_ff.avg_y[STICK_W-1] ? STICK_W'(-mid_ff.avg_y) : STICK_W'(mid_ff.avg_y);
      radius_sq = 33'(32'(mag_x) * 32'(mag_x)) + 33'(32'(mag_y) * 32'(mag_y));
      ay_q      = {1'b0, mag_y, 16'b0};
      t30_prod  = 33'(TAN30_Q16) * 33'(mag_x);
      t60_prod  = 33'(TAN60_Q16) * 33'(mag_x);
      dir_bits  = '0;
      if (!mid_ff.remote && radius_sq > RADIUS_SQ_LIMIT) begin
         if (mag_x != '0 && ay_q < t60_prod) begin
            if (mid_ff.avg_x > 0) begin
               dir_bits[BIT_RIGHT] = 1'b1;
            end else begin
               dir_bits[BIT_LEFT] = 1'b1;
            end
         end
         if (mag_x == '0 || ay_q > t30_prod) begin
            if (mid_ff.avg_y > 0) begin
               dir_bits[BIT_UP] = 1'b1;
            end else begin
               dir_bits[BIT_DOWN] = 1'b1;
            end
         end
      end
      state = mid_ff.bits | dir_bits;

      rsp_in.pad_slot      = mid_ff.pad_slot;
      rsp_in.pad_state     = state;
      rsp_in.pressed_now   = state & ~prev_pad_ff;
      rsp_in.released_now  = prev_pad_ff & ~state;
      rsp_in.avg_x         = mid_ff.avg_x;
      rsp_in.avg_y         = mid_ff.avg_y;
      rsp_in.pad_wrapped   = mid_ff.pad_wrapped;
      rsp_in.touch_slot    = mid_ff.touch_slot;
      rsp_in.touch_col     = mid_ff.touch_col;
      rsp_in.touch_row     = mid_ff.touch_row;
      rsp_in.touch_valid   = mid_ff.touch_valid;
      rsp_in.touch_wrapped = mid_ff.touch_wrapped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pad_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            prev_pad_ff  <= state;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pad_slot      = rsp_ff.pad_slot;
   assign rsp_chan.pad_state     = rsp_ff.pad_state;
   assign rsp_chan.pressed_now   = rsp_ff.pressed_now;
   assign rsp_chan.released_now  = rsp_ff.released_now;
   assign rsp_chan.avg_x         = rsp_ff.avg_x;
   assign rsp_chan.avg_y         = rsp_ff.avg_y;
   assign rsp_chan.pad_wrapped   = rsp_ff.pad_wrapped;
   assign rsp_chan.touch_slot    = rsp_ff.touch_slot;
   assign rsp_chan.touch_col     = rsp_ff.touch_col;
   assign rsp_chan.touch_row     = rsp_ff.touch_row;
   assign rsp_chan.touch_valid   = rsp_ff.touch_valid;
   assign rsp_chan.touch_wrapped = rsp_ff.touch_wrapped;

endmodule

/* test/psru_checker.sv */
// Pad ring update checker: predicts each result from the poll ticks and compares it.
`timescale 1ns / 1ps
module psru_checker
   import psru_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   psru_req_if         req,
   psru_rsp_if         rsp,
   psru_csr_if         csr,
   output int          fail_count,
   output int          pending
);

   localparam int HIST_LEN = AVG_DEPTH_DEFAULT - 1;

   logic             remote_mode;
   logic [PAD_W-1:0] last_pad;
   int               pad_ptr;
   int               touch_ptr;
   int               hist_x [AVG_DEPTH_DEFAULT];
   int               hist_y [AVG_DEPTH_DEFAULT];
   int               errors;
   result_type       ring_updates [$];

   function automatic logic [PAD_W-1:0] stick_direction(input int x, input int y);
      longint           r2;
      longint           ax;
      longint           ay_q;
      logic [PAD_W-1:0] dir;
      dir = '0;
      r2 = longint'(x) * x + longint'(y) * y;
      if (r2 > longint'(RADIUS_SQ_LIMIT)) begin
         ax   = (x < 0) ? -longint'(x) : longint'(x);
         ay_q = ((y < 0) ? -longint'(y) : longint'(y)) << 16;
         if (x != 0 && ay_q < longint'(TAN60_Q16) * ax)
            dir[(x > 0) ? BIT_RIGHT : BIT_LEFT] = 1'b1;
         if (x == 0 || ay_q > longint'(TAN30_Q16) * ax)
            dir[(y > 0) ? BIT_UP : BIT_DOWN] = 1'b1;
      end
      return dir;
   endfunction

   function automatic result_type next_ring_update(
      input logic [PAD_W-1:0]          bits,
      input logic signed [STICK_W-1:0] sx,
      input logic signed [STICK_W-1:0] sy,
      input logic [TOUCH_W-1:0]        tx,
      input logic [TOUCH_W-1:0]        ty,
      input logic                      tp
   );
      result_type       r;
      int               mx;
      int               my;
      int               i;
      logic [PAD_W-1:0] state;
      mx = int'(sx);
      my = int'(sy);
      if (remote_mode) begin
         state         = bits & REMOTE_MASK;
         r.touch_valid = bits[REMOTE_TOUCH_BIT];
      end else begin
         for (i = 0; i < HIST_LEN; i++) begin
            mx += hist_x[i];
            my += hist_y[i];
         end
         for (i = 0; i + 1 < HIST_LEN; i++) begin
            hist_x[i] = hist_x[i+1];
            hist_y[i] = hist_y[i+1];
         end
         if (HIST_LEN > 0) begin
            hist_x[HIST_LEN-1] = int'(sx);
            hist_y[HIST_LEN-1] = int'(sy);
         end
         mx            = mx / AVG_DEPTH_DEFAULT;
         my            = my / AVG_DEPTH_DEFAULT;
         state         = (bits & LOCAL_MASK) | stick_direction(mx, my);
         r.touch_valid = tp;
      end
      r.pad_slot      = SLOT_W'(pad_ptr);
      r.pad_wrapped   = (pad_ptr == 0);
      r.touch_slot    = SLOT_W'(touch_ptr);
      r.touch_wrapped = (touch_ptr == 0);
      pad_ptr         = (pad_ptr + 1) % PAD_SLOTS_DEFAULT;
      touch_ptr       = (touch_ptr + 1) % TOUCH_SLOTS_DEFAULT;
      r.pad_state     = state;
      r.pressed_now   = state & ~last_pad;
      r.released_now  = last_pad & ~state;
      r.avg_x         = STICK_W'(mx);
      r.avg_y         = STICK_W'(my);
      r.touch_col     = tx;
      r.touch_row     = ty;
      last_pad        = state;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         remote_mode = 1'b0;
         last_pad    = '0;
         pad_ptr     = 0;
         touch_ptr   = 0;
         foreach (hist_x[i]) begin
            hist_x[i] = 0;
            hist_y[i] = 0;
         end
         ring_updates.delete();
      end else begin
         if (csr.valid && csr.ready)
            remote_mode = csr.remote_mode;
         if (req.valid && req.ready)
            ring_updates = {ring_updates,
                            next_ring_update(req.pad_bits, req.stick_x, req.stick_y,
                                             req.touch_x, req.touch_y, req.touch_pressed)};
         if (rsp.valid && rsp.ready) begin
            if (ring_updates.size() == 0) begin
               $error("result transfer with no poll tick outstanding");
               errors++;
            end else begin
               want = ring_updates.pop_front();
               check_field("pad_slot", 32'(want.pad_slot), 32'(rsp.pad_slot));
               check_field("pad_state", want.pad_state, rsp.pad_state);
               check_field("pressed_now", want.pressed_now, rsp.pressed_now);
               check_field("released_now", want.released_now, rsp.released_now);
               check_field("avg_x", 32'(want.avg_x), 32'(rsp.avg_x));
               check_field("avg_y", 32'(want.avg_y), 32'(rsp.avg_y));
               check_field("pad_wrapped", 32'(want.pad_wrapped), 32'(rsp.pad_wrapped));
               check_field("touch_slot", 32'(want.touch_slot), 32'(rsp.touch_slot));
               check_field("touch_col", 32'(want.touch_col), 32'(rsp.touch_col));
               check_field("touch_row", 32'(want.touch_row), 32'(rsp.touch_row));
               check_field("touch_valid", 32'(want.touch_valid), 32'(rsp.touch_valid));
               check_field("touch_wrapped", 32'(want.touch_wrapped),
                           32'(rsp.touch_wrapped));
            end
         end
      end
      fail_count <= errors;
      pending    <= ring_updates.size();
   end

endmodule

/* test/tb_top.sv */
// Testbench top for the pad sample ring update core: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_top
   import psru_pkg::*;
();

   localparam int STALL_PCT      = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_TICKS    = 290;

   logic clock;
   logic reset;
   logic no_idle;
   int   fail_count;
   int   pending;
   int   stuck_cycles;

   logic [PAD_W-1:0]          held_bits;
   logic signed [STICK_W-1:0] held_x;
   logic signed [STICK_W-1:0] held_y;

   psru_req_if req_chan ();
   psru_rsp_if rsp_chan ();
   psru_csr_if csr_chan ();

   pad_sample_ring_update_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   psru_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .csr        (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = no_idle || ($urandom_range(99) >= STALL_PCT);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("pad_sample_ring_update_core: mismatch");
         $finish;
      end
   end

   task automatic drain_ring_updates();
      req_chan.valid = 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic write_mode(input logic remote);
      drain_ring_updates();
      csr_chan.remote_mode = remote;
      csr_chan.valid       = 1'b1;
      do
         @(posedge clock);
      while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic send_tick(
      input logic [PAD_W-1:0]          bits,
      input logic signed [STICK_W-1:0] sx,
      input logic signed [STICK_W-1:0] sy,
      input logic [TOUCH_W-1:0]        tx,
      input logic [TOUCH_W-1:0]        ty,
      input logic                      tp
   );
      while (!no_idle && $urandom_range(99) < STALL_PCT) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.pad_bits      = bits;
      req_chan.stick_x       = sx;
      req_chan.stick_y       = sy;
      req_chan.touch_x       = tx;
      req_chan.touch_y       = ty;
      req_chan.touch_pressed = tp;
      req_chan.valid         = 1'b1;
      do
         @(posedge clock);
      while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic random_tick();
      logic [TOUCH_W-1:0] tx;
      logic [TOUCH_W-1:0] ty;
      case ($urandom_range(3))
         0: held_bits = held_bits;
         1: held_bits = held_bits ^ (32'h1 << $urandom_range(31));
         default: held_bits = $urandom;
      endcase
      if ($urandom_range(9) >= 3) begin
         case ($urandom_range(9))
            0: begin
               held_x = STICK_W'($urandom);
               held_y = STICK_W'($urandom);
            end
            1, 2: begin
               held_x = STICK_W'($urandom_range(100) - 50);
               held_y = STICK_W'($urandom_range(100) - 50);
            end
            default: begin
               held_x = STICK_W'($urandom_range(308) - 154);
               held_y = STICK_W'($urandom_range(308) - 154);
            end
         endcase
      end
      tx = TOUCH_W'($urandom_range(1) ? $urandom : $urandom_range(399));
      ty = TOUCH_W'($urandom_range(1) ? $urandom : $urandom_range(239));
      send_tick(held_bits, held_x, held_y, tx, ty, 1'($urandom_range(1)));
   endtask

   initial begin
      logic phase_modes [6];
      reset                  = 1'b1;
      no_idle                = 1'b0;
      held_bits              = '0;
      held_x                 = '0;
      held_y                 = '0;
      req_chan.valid         = 1'b0;
      req_chan.pad_bits      = '0;
      req_chan.stick_x       = '0;
      req_chan.stick_y       = '0;
      req_chan.touch_x       = '0;
      req_chan.touch_y       = '0;
      req_chan.touch_pressed = 1'b0;
      csr_chan.valid         = 1'b0;
      csr_chan.remote_mode   = 1'b0;
      phase_modes            = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // local mode: masks, stick extremes, radius border, sector edges, truncation
      write_mode(1'b0);
      send_tick(32'hFFFF_FFFF, 0, 0, 16'h0000, 16'h0000, 1'b1);
      send_tick(32'h0000_0000, 154, -154, 16'hFFFF, 16'hFFFF, 1'b0);
      send_tick(32'hFFFF_C000, -154, 154, 16'h1234, 16'hABCD, 1'b1);
      send_tick(32'h0000_1555, 32767, 32767, 16'h8000, 16'h7FFF, 1'b0);
      send_tick(32'h0000_2AAA, -32768, -32768, 16'h7FFF, 16'h8000, 1'b1);
      send_tick(32'h0000_3FFF, -32768, 32767, 16'h00FF, 16'hFF00, 1'b0);
      repeat (3) send_tick(32'h0000_0001, 40, 0, 16'd10, 16'd20, 1'b1);
      repeat (3) send_tick(32'h0000_0001, 41, 0, 16'd11, 16'd21, 1'b1);
      repeat (3) send_tick(32'h0000_0000, 0, -41, 16'd12, 16'd22, 1'b0);
      repeat (2) send_tick(32'h0000_0000, -1, -1, 16'd13, 16'd23, 1'b0);
      repeat (3) send_tick(32'h0000_2000, -100, 58, 16'd14, 16'd24, 1'b1);

      // remote mode: remote mask, touch flag from the pad word, raw stick
      write_mode(1'b1);
      send_tick(32'hFFFF_FFFF, -32768, 32767, 16'hFFFF, 16'h0000, 1'b0);
      send_tick(32'h0FEF_FFFF, 32767, -32768, 16'h0000, 16'hFFFF, 1'b1);
      send_tick(32'h0010_0000, 0, 0, 16'd100, 16'd200, 1'b0);
      send_tick(32'hF000_0000, 5, -5, 16'd300, 16'd100, 1'b1);

      for (int p = 0; p < 6; p++) begin
         write_mode(phase_modes[p]);
         no_idle = (p == 2);
         for (int i = 0; i < PHASE_TICKS; i++) begin
            if (p == 1 && i == PHASE_TICKS / 2)
               drain_ring_updates();
            random_tick();
         end
         no_idle = 1'b0;
      end

      drain_ring_updates();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("pad_sample_ring_update_core: match");
      else
         $display("pad_sample_ring_update_core: mismatch");
      $finish;
   end

endmodule

/* pad_sample_ring_update_core.f */
src/psru_pkg.sv
src/psru_if.sv
src/pad_sample_ring_update_core.sv
test/psru_checker.sv
test/tb_top.sv
